@@ rtl/wqtt_pkg.sv @@
`timescale 1ns / 1ps

package wqtt_pkg;

  // Scan event codes carried on req_type.
  localparam logic [1:0] REQ_OTHER = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_EOL   = 2'd2;

  // Token codes driven on token_kind.
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_I_OPEN  = 3'd1;
  localparam logic [2:0] KIND_I_CLOSE = 3'd2;
  localparam logic [2:0] KIND_B_OPEN  = 3'd3;
  localparam logic [2:0] KIND_B_CLOSE = 3'd4;

  // Apostrophe run lengths that select the quote rule.
  localparam logic [7:0] RUN_ITALIC = 8'd2;
  localparam logic [7:0] RUN_BOLD   = 8'd3;
  localparam logic [7:0] RUN_BOLD_X = 8'd4;

  // One scan event as held in the input register.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] run_length;
    logic       ok_io;
    logic       ok_ic;
    logic       ok_bo;
    logic       ok_bc;
    logic       recovering;
  } event_t;

  // Span tracking state.
  typedef struct packed {
    logic in_italic;
    logic in_bold;
    logic nested;
    logic queued_italic;
    logic queued_bold;
  } span_state_t;

endpackage

@@ rtl/wiki_quote_toggle_tracker_top.sv @@
`timescale 1ns / 1ps

// Bold and italic span tracker for wiki apostrophe markup. Each scan event
// (an apostrophe run, a line end or any other position) gives exactly one
// result: a token with its width and the span flags after the event. An event
// passes through an input register, one level of flag logic and a result
// register. Its result is held in the result register until it is taken.
// One event is taken on every clock while the result side keeps up. The span
// state is updated as each event moves into the result register, which is
// what lets the next event follow in the very next cycle.
module wiki_quote_toggle_tracker_top
  import wqtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] run_length,
  input  logic       allow_italic_open,
  input  logic       allow_italic_close,
  input  logic       allow_bold_open,
  input  logic       allow_bold_close,
  input  logic       recovering,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] token_kind,
  output logic [7:0] token_width,
  output logic       italic_active,
  output logic       bold_active
);

  event_t      held;
  logic        held_valid;
  span_state_t st;
  span_state_t st_next;
  logic [2:0]  kind_next;
  logic [7:0]  width_next;
  logic        done;
  logic        both;
  logic        any_ok;
  logic        advance;

  // The held event moves on when the result register is empty or is being taken.
  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      held <= '{req_type, run_length, allow_italic_open, allow_italic_close,
                allow_bold_open, allow_bold_close, recovering};
    end
  end

  // Quote rule: queued toggle first, then line end or apostrophe run.
  always_comb begin
    st_next    = st;
    kind_next  = KIND_NONE;
    width_next = 8'd0;
    done       = 1'b0;
    both       = 1'b0;
    any_ok     = held.ok_io || held.ok_ic || held.ok_bo || held.ok_bc;
    if (!held.recovering) begin
      if (st.queued_italic || st.queued_bold) begin
        if (st.queued_bold) begin
          st_next.queued_bold = 1'b0;
          if (st.in_bold) begin
            if (held.ok_bc) begin
              st_next.in_bold = 1'b0;
              st_next.nested  = 1'b0;
              kind_next       = KIND_B_CLOSE;
              done            = 1'b1;
            end
          end else if (held.ok_bo) begin
            st_next.in_bold = 1'b1;
            if (st.in_italic) begin
              st_next.nested = 1'b1;
            end
            kind_next = KIND_B_OPEN;
            done      = 1'b1;
          end
        end else begin
          st_next.queued_italic = 1'b0;
          if (st.in_italic) begin
            if (held.ok_ic) begin
              st_next.in_italic = 1'b0;
              kind_next         = KIND_I_CLOSE;
              done              = 1'b1;
            end
          end else if (held.ok_io) begin
            st_next.in_italic = 1'b1;
            kind_next         = KIND_I_OPEN;
            done              = 1'b1;
          end
        end
        // A refused queued toggle drops the whole queue.
        if (!done) begin
          st_next.queued_italic = 1'b0;
          st_next.queued_bold   = 1'b0;
        end
      end
      if (!done) begin
        both = st.in_italic && st.in_bold;
        if (held.req_type == REQ_EOL) begin
          // Close the innermost open span, zero-width.
          if (st.in_bold && (!st.in_italic || st.nested)) begin
            if (held.ok_bc) begin
              st_next.in_bold = 1'b0;
              st_next.nested  = 1'b0;
              kind_next       = KIND_B_CLOSE;
            end
          end else if (st.in_italic && held.ok_ic) begin
            st_next.in_italic = 1'b0;
            kind_next         = KIND_I_CLOSE;
          end
        end else if (held.req_type == REQ_RUN && held.run_length >= RUN_ITALIC
                     && any_ok) begin
          if (held.run_length == RUN_ITALIC && both && st.nested && held.ok_bc) begin
            // Inner bold must close before the italic around it.
            st_next.in_bold = 1'b0;
            st_next.nested  = 1'b0;
            kind_next       = KIND_B_CLOSE;
          end else if (held.run_length == RUN_BOLD && both && !st.nested
                       && held.ok_ic) begin
            // Inner italic must close before the bold around it.
            st_next.in_italic = 1'b0;
            kind_next         = KIND_I_CLOSE;
          end else if (held.run_length == RUN_ITALIC) begin
            if (st.in_italic && held.ok_ic) begin
              st_next.in_italic = 1'b0;
              kind_next         = KIND_I_CLOSE;
              width_next        = held.run_length;
            end else if (held.ok_io) begin
              st_next.in_italic = 1'b1;
              st_next.nested    = 1'b0;
              kind_next         = KIND_I_OPEN;
              width_next        = held.run_length;
            end
          end else if (held.run_length == RUN_BOLD || held.run_length == RUN_BOLD_X) begin
            if (st.in_bold && held.ok_bc) begin
              st_next.in_bold = 1'b0;
              st_next.nested  = 1'b0;
              kind_next       = KIND_B_CLOSE;
              width_next      = held.run_length;
            end else if (held.ok_bo) begin
              st_next.in_bold = 1'b1;
              if (st.in_italic) begin
                st_next.nested = 1'b1;
              end
              kind_next  = KIND_B_OPEN;
              width_next = held.run_length;
            end
          end else if ((both && st.nested) || (!st.in_italic && st.in_bold)) begin
            // Five or more: close bold now, toggle italic next.
            if (held.ok_bc) begin
              st_next.in_bold       = 1'b0;
              st_next.nested        = 1'b0;
              st_next.queued_italic = 1'b1;
              kind_next             = KIND_B_CLOSE;
              width_next            = held.run_length;
            end
          end else if (st.in_italic) begin
            // Five or more: close italic now, toggle bold next.
            if (held.ok_ic) begin
              st_next.in_italic   = 1'b0;
              st_next.queued_bold = 1'b1;
              kind_next           = KIND_I_CLOSE;
              width_next          = held.run_length;
            end
          end else if (held.ok_io) begin
            // Five or more with nothing open: open italic, then bold.
            st_next.in_italic   = 1'b1;
            st_next.queued_bold = 1'b1;
            kind_next           = KIND_I_OPEN;
            width_next          = held.run_length;
          end
        end
      end
    end
  end

  // Span state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        st <= st_next;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= held_valid;
      end
    end
    if (advance) begin
      token_kind    <= kind_next;
      token_width   <= width_next;
      italic_active <= st_next.in_italic;
      bold_active   <= st_next.in_bold;
    end
  end

`ifndef SYNTHESIS
  // Only one toggle is ever queued at a time.
  assert property (@(posedge clk) disable iff (rst)
    !(st.queued_italic && st.queued_bold))
    else $error("both toggles queued");

  // Nesting is only recorded while bold is open.
  assert property (@(posedge clk) disable iff (rst) st.nested |-> st.in_bold)
    else $error("nested flag set without bold span");

  // The span state moves only with an event.
  assert property (@(posedge clk) disable iff (rst) !advance |=> $stable(st))
    else $error("span state changed without an event");

  // An event in error recovery leaves the state alone.
  assert property (@(posedge clk) disable iff (rst)
    advance && held.recovering |=> $stable(st))
    else $error("recovering event changed span state");

  // A result with width always carries a token.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_width != 8'd0 |-> token_kind != KIND_NONE)
    else $error("width without token");
`endif

endmodule

@@ bench/wiki_quote_toggle_tracker_top_test.sv @@
`timescale 1ns / 1ps

module wiki_quote_toggle_tracker_top_test
  import wqtt_pkg::*;
();

  // Request code that the block treats as another position.
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  // Shortest run that toggles both spans.
  localparam logic [7:0] RUN_BOTH = 8'd5;
  // Permission masks in the order italic open, italic close, bold open, bold close.
  localparam logic [3:0] ALLOW_ALL    = 4'b1111;
  localparam logic [3:0] ALLOW_NONE   = 4'b0000;
  localparam logic [3:0] ALLOW_ITALIC = 4'b1100;
  localparam int unsigned RANDOM_EVENTS = 850;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] width;
    logic       italic;
    logic       bold;
  } token_t;

  typedef struct packed {
    event_t ev;
    logic   typed;
    token_t want;
  } script_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_OTHER;
  logic [7:0] run_length = '0;
  logic       allow_italic_open = 1'b0;
  logic       allow_italic_close = 1'b0;
  logic       allow_bold_open = 1'b0;
  logic       allow_bold_close = 1'b0;
  logic       recovering = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] token_kind;
  logic [7:0] token_width;
  logic       italic_active;
  logic       bold_active;

  // Expected token of the event on the input, where the script gives one.
  logic        ev_typed = 1'b0;
  token_t      ev_want = '0;

  span_state_t spans = '0;
  token_t      pending_tokens[$];
  script_row_t scan_script[$];
  int          mismatches = 0;

  wiki_quote_toggle_tracker_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_type           (req_type),
    .run_length         (run_length),
    .allow_italic_open  (allow_italic_open),
    .allow_italic_close (allow_italic_close),
    .allow_bold_open    (allow_bold_open),
    .allow_bold_close   (allow_bold_close),
    .recovering         (recovering),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .token_kind         (token_kind),
    .token_width        (token_width),
    .italic_active      (italic_active),
    .bold_active        (bold_active)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Span open and close steps; each fails without effect when the token is not allowed.
  function automatic logic open_italic(input logic ok, input logic [7:0] w, inout token_t t);
    if (!ok) return 1'b0;
    spans.in_italic = 1'b1;
    t.kind = KIND_I_OPEN;
    t.width = w;
    return 1'b1;
  endfunction

  function automatic logic close_italic(input logic ok, input logic [7:0] w, inout token_t t);
    if (!ok) return 1'b0;
    spans.in_italic = 1'b0;
    t.kind = KIND_I_CLOSE;
    t.width = w;
    return 1'b1;
  endfunction

  function automatic logic open_bold(input logic ok, input logic [7:0] w, inout token_t t);
    if (!ok) return 1'b0;
    spans.in_bold = 1'b1;
    if (spans.in_italic) spans.nested = 1'b1;
    t.kind = KIND_B_OPEN;
    t.width = w;
    return 1'b1;
  endfunction

  function automatic logic close_bold(input logic ok, input logic [7:0] w, inout token_t t);
    if (!ok) return 1'b0;
    spans.in_bold = 1'b0;
    spans.nested = 1'b0;
    t.kind = KIND_B_CLOSE;
    t.width = w;
    return 1'b1;
  endfunction

  // Works out the token for one scan event and advances the span state.
  function automatic token_t track_spans(input event_t ev);
    token_t     t;
    logic       done;
    logic       both;
    logic [7:0] n;
    t = '0;
    done = 1'b0;
    n = ev.run_length;
    if (!ev.recovering) begin
      // A pending zero-width toggle comes first; if refused, the queue is dropped.
      if (spans.queued_bold) begin
        spans.queued_bold = 1'b0;
        if (spans.in_bold) done = close_bold(ev.ok_bc, 8'd0, t);
        else done = open_bold(ev.ok_bo, 8'd0, t);
        if (!done) spans.queued_italic = 1'b0;
      end else if (spans.queued_italic) begin
        spans.queued_italic = 1'b0;
        if (spans.in_italic) done = close_italic(ev.ok_ic, 8'd0, t);
        else done = open_italic(ev.ok_io, 8'd0, t);
      end
      if (!done) begin
        if (ev.req_type == REQ_EOL) begin
          // The innermost open span is closed at a line end.
          if (spans.in_bold && (!spans.in_italic || spans.nested)) begin
            void'(close_bold(ev.ok_bc, 8'd0, t));
          end else if (spans.in_italic) begin
            void'(close_italic(ev.ok_ic, 8'd0, t));
          end
        end else if (ev.req_type == REQ_RUN && n >= RUN_ITALIC &&
                     (ev.ok_io || ev.ok_ic || ev.ok_bo || ev.ok_bc)) begin
          both = spans.in_italic && spans.in_bold;
          if (n == RUN_ITALIC && both && spans.nested && ev.ok_bc) begin
            void'(close_bold(ev.ok_bc, 8'd0, t));
          end else if (n == RUN_BOLD && both && !spans.nested && ev.ok_ic) begin
            void'(close_italic(ev.ok_ic, 8'd0, t));
          end else if (n == RUN_ITALIC) begin
            if (spans.in_italic && ev.ok_ic) begin
              void'(close_italic(ev.ok_ic, n, t));
            end else if (ev.ok_io) begin
              void'(open_italic(ev.ok_io, n, t));
              spans.nested = 1'b0;
            end
          end else if (n == RUN_BOLD || n == RUN_BOLD_X) begin
            if (spans.in_bold && ev.ok_bc) void'(close_bold(ev.ok_bc, n, t));
            else void'(open_bold(ev.ok_bo, n, t));
          end else if (both && spans.nested) begin
            if (close_bold(ev.ok_bc, n, t)) spans.queued_italic = 1'b1;
          end else if (spans.in_italic) begin
            if (close_italic(ev.ok_ic, n, t)) spans.queued_bold = 1'b1;
          end else if (spans.in_bold) begin
            if (close_bold(ev.ok_bc, n, t)) spans.queued_italic = 1'b1;
          end else if (open_italic(ev.ok_io, n, t)) begin
            spans.queued_bold = 1'b1;
          end
        end
      end
    end
    t.italic = spans.in_italic;
    t.bold = spans.in_bold;
    return t;
  endfunction

  task automatic add_row(input logic [1:0] req, input logic [7:0] len, input logic [3:0] allow,
                         input logic rec, input logic typed, input logic [2:0] kind,
                         input logic [7:0] width, input logic italic, input logic bold);
    script_row_t row;
    row.ev = {req, len, allow, rec};
    row.typed = typed;
    row.want = {kind, width, italic, bold};
    scan_script.push_back(row);
  endtask

  // Random scan event, weighted towards quote runs of the lengths that matter.
  function automatic event_t draw_scan_event();
    event_t      ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) ev.req_type = REQ_RUN;
    else if (pick < 75) ev.req_type = REQ_EOL;
    else if (pick < 92) ev.req_type = REQ_OTHER;
    else ev.req_type = REQ_UNDEF;
    pick = $urandom_range(0, 99);
    if (ev.req_type != REQ_RUN) ev.run_length = 8'($urandom_range(0, 255));
    else if (pick < 30) ev.run_length = RUN_ITALIC;
    else if (pick < 55) ev.run_length = RUN_BOLD;
    else if (pick < 65) ev.run_length = RUN_BOLD_X;
    else if (pick < 85) ev.run_length = RUN_BOTH;
    else if (pick < 90) ev.run_length = 8'($urandom_range(0, 1));
    else if (pick < 95) ev.run_length = 8'($urandom_range(6, 20));
    else ev.run_length = 8'($urandom_range(21, 255));
    ev.ok_io = $urandom_range(0, 9) != 0;
    ev.ok_ic = $urandom_range(0, 9) != 0;
    ev.ok_bo = $urandom_range(0, 9) != 0;
    ev.ok_bc = $urandom_range(0, 9) != 0;
    ev.recovering = $urandom_range(0, 11) == 0;
    return ev;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Predicts on every input transfer and checks every output transfer in order.
  always @(posedge clk) begin
    token_t seen;
    token_t want;
    token_t predicted;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted = track_spans({req_type, run_length, allow_italic_open, allow_italic_close,
                                 allow_bold_open, allow_bold_close, recovering});
        if (ev_typed) pending_tokens.push_back(ev_want);
        else pending_tokens.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        seen = {token_kind, token_width, italic_active, bold_active};
        if (pending_tokens.size() == 0) begin
          $display("%0t: expected no result, actual token_kind %0d", $time, seen.kind);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", int'(want.kind), int'(seen.kind));
          check_field("token_width", int'(want.width), int'(seen.width));
          check_field("italic_active", int'(want.italic), int'(seen.italic));
          check_field("bold_active", int'(want.bold), int'(seen.bold));
        end
      end
    end
  end

  // Result side: may stall before each transfer, except the first 40 of every 160 transfers.
  initial begin : result_side
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    forever begin
      if ((taken % 160) < 40) hold = 0;
      else hold = $urandom_range(0, 12);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  // Event source: directed script first, then random events.
  initial begin : event_source
    script_row_t row;
    int unsigned idx;
    int unsigned gap;
    int unsigned total;

    // Reset state, widest run opening italic with bold queued, queue drained.
    add_row(REQ_OTHER, 8'd0,   ALLOW_ALL, 1'b0, 1'b1, KIND_NONE,   8'd0,   1'b0, 1'b0);
    add_row(REQ_RUN,   8'd255, ALLOW_ALL, 1'b0, 1'b1, KIND_I_OPEN, 8'd255, 1'b1, 1'b0);
    add_row(REQ_OTHER, 8'd0,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0,   1'b0, 1'b0);
    // Italic run while bold is nested inside italic closes bold first.
    add_row(REQ_RUN,   8'd2,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0,   1'b0, 1'b0);
    add_row(REQ_EOL,   8'd0,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0,   1'b0, 1'b0);
    // Short runs, recovery and no permissions give no token.
    add_row(REQ_RUN,   8'd0,   ALLOW_ALL,  1'b0, 1'b1, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd1,   ALLOW_ALL,  1'b0, 1'b1, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd3,   ALLOW_ALL,  1'b1, 1'b1, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd3,   ALLOW_NONE, 1'b0, 1'b1, KIND_NONE, 8'd0, 1'b0, 1'b0);
    // Bold then italic inside it; a bold run then closes italic first.
    add_row(REQ_RUN,   8'd3,   ALLOW_ALL, 1'b0, 1'b1, KIND_B_OPEN, 8'd3, 1'b0, 1'b1);
    add_row(REQ_RUN,   8'd2,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd3,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd4,   ALLOW_ALL, 1'b0, 1'b0, KIND_NONE,   8'd0, 1'b0, 1'b0);
    // The undefined request code acts as another position.
    add_row(REQ_UNDEF, 8'd2,   ALLOW_ALL, 1'b0, 1'b1, KIND_NONE,   8'd0, 1'b0, 1'b0);
    // Queued bold toggle refused: the queue is dropped and the run handled.
    add_row(REQ_RUN,   RUN_BOTH, ALLOW_ITALIC, 1'b0, 1'b1, KIND_I_OPEN, 8'd5, 1'b1, 1'b0);
    add_row(REQ_RUN,   8'd2,     ALLOW_ITALIC, 1'b0, 1'b0, KIND_NONE,   8'd0, 1'b0, 1'b0);
    // Queued toggles taken on a quote run and on another position.
    add_row(REQ_RUN,   RUN_BOTH, ALLOW_ALL, 1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd2,     ALLOW_ALL, 1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   RUN_BOTH, ALLOW_ALL, 1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_OTHER, 8'd0,     ALLOW_ALL, 1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    // Line ends close the inner span, then the outer one, then nothing.
    add_row(REQ_RUN,   8'd3,   ALLOW_ALL,  1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_RUN,   8'd2,   ALLOW_ALL,  1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_EOL,   8'd0,   ALLOW_ALL,  1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_EOL,   8'd0,   ALLOW_ALL,  1'b0, 1'b0, KIND_NONE, 8'd0, 1'b0, 1'b0);
    add_row(REQ_EOL,   8'd255, ALLOW_NONE, 1'b0, 1'b1, KIND_NONE, 8'd0, 1'b0, 1'b0);

    total = scan_script.size() + RANDOM_EVENTS;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < total; idx++) begin
      // The first 40 of every 160 events run back to back with no gaps.
      if ((idx % 160) < 40) gap = 0;
      else gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (idx < scan_script.size()) begin
        row = scan_script[idx];
      end else begin
        row.ev = draw_scan_event();
        row.typed = 1'b0;
        row.want = '0;
      end
      in_valid <= 1'b1;
      req_type <= row.ev.req_type;
      run_length <= row.ev.run_length;
      allow_italic_open <= row.ev.ok_io;
      allow_italic_close <= row.ev.ok_ic;
      allow_bold_open <= row.ev.ok_bo;
      allow_bold_close <= row.ev.ok_bc;
      recovering <= row.ev.recovering;
      ev_typed <= row.typed;
      ev_want <= row.want;
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;

    // Let the last transfer be recorded, drain the outstanding tokens, then
    // watch on for any extra result.
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("wiki_quote_toggle_tracker_top test passed");
    end else begin
      $display("wiki_quote_toggle_tracker_top test failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("wiki_quote_toggle_tracker_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/wqtt_pkg.sv
rtl/wiki_quote_toggle_tracker_top.sv
bench/wiki_quote_toggle_tracker_top_test.sv
